// ----- hw/rtl/bitmap_region_engine_assert.svh -----
// Assertion macros shared by the bitmap region engine RTL.
`ifndef BITMAP_REGION_ENGINE_ASSERT_SVH
`define BITMAP_REGION_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bre_pkg.sv -----
// Types, constants and helper functions of the bitmap region engine.
package bre_pkg;

  localparam int DATA_W  = 64;
  localparam int BIT_W   = 6;
  localparam int WORD_W  = 7;
  localparam int CFG_W   = 13;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int RUN_W   = 13;
  localparam int CNT_W   = 7;

  localparam logic [CFG_W-1:0]  BIU_RESET = 13'd4096;
  localparam logic [DATA_W-1:0] WORD_ONES = '1;
  localparam logic [CNT_W-1:0]  FULL_WORD = 7'd64;
  localparam logic [BIT_W-1:0]  TOP_BIT   = 6'd63;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;
  localparam logic [1:0] OP_COUNT  = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WORK,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [START_W-1:0] start_req;
    logic [LEN_W-1:0]   length;
    logic               value;
  } in_item_t;

  typedef struct packed {
    logic             bit_out;
    logic [RUN_W-1:0] run_count;
    logic             status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic             value;
    logic             first;
    logic             last_reg;
    logic             lim_last;
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
    logic [BIT_W-1:0] lim_bit;
  } wu_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] new_word;
    logic              bit_val;
    logic [CNT_W-1:0]  ones;
  } wu_res_t;

  typedef struct packed {
    logic idle;
    logic clearing;
    logic mem_we;
  } seq_stat_t;

  // Number of consecutive ones from bit 0 upward (64 when the word is all ones).
  function automatic logic [CNT_W-1:0] trailing_ones(input logic [DATA_W-1:0] w);
    logic [CNT_W-1:0] t;
    t = FULL_WORD;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        t = CNT_W'(i);
      end
    end
    return t;
  endfunction

endpackage

// ----- hw/rtl/bre_store.sv -----
// Bitmap word memory: one write port and one registered read port.
module bre_store #(
  parameter int NUM_WORDS = 64,
  parameter int AW        = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bre_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [bre_pkg::DATA_W-1:0] rd_data
);
  import bre_pkg::*;

  logic [DATA_W-1:0] mem_r [NUM_WORDS];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/bre_word_unit.sv -----
// Per-word datapath: region mask, fill/clear/toggle and run length within a word.
module bre_word_unit (
  input  bre_pkg::wu_ctl_t             ctl,
  input  logic [bre_pkg::DATA_W-1:0]   rd_word,
  output bre_pkg::wu_res_t             res
);
  import bre_pkg::*;

  logic [DATA_W-1:0] lo_mask;
  logic [DATA_W-1:0] hi_mask;
  logic [DATA_W-1:0] reg_mask;
  logic [DATA_W-1:0] match;
  logic [DATA_W-1:0] below;
  logic [DATA_W-1:0] lim_mask;
  logic [DATA_W-1:0] probe;

  always_comb begin
    lo_mask  = ctl.first    ? (WORD_ONES << ctl.lo) : WORD_ONES;
    hi_mask  = ctl.last_reg ? (WORD_ONES >> (TOP_BIT - ctl.hi)) : WORD_ONES;
    reg_mask = lo_mask & hi_mask;

    case (ctl.opcode)
      OP_TOGGLE: res.new_word = rd_word ^ reg_mask;
      OP_WRITE:  res.new_word = ctl.value ? (rd_word | reg_mask) : (rd_word & ~reg_mask);
      default:   res.new_word = rd_word;
    endcase

    // Bits below the run start count as matches so that the trailing-ones
    // count includes them; the caller subtracts the start offset.
    match    = ctl.value ? rd_word : ~rd_word;
    below    = ctl.first ? ~(WORD_ONES << ctl.lo) : '0;
    lim_mask = ctl.lim_last ? (WORD_ONES >> (TOP_BIT - ctl.lim_bit)) : WORD_ONES;
    probe    = (match | below) & lim_mask;
    res.ones = trailing_ones(probe);

    res.bit_val = rd_word[ctl.lo];
  end

endmodule

// ----- hw/rtl/bre_seq.sv -----
// Command sequencer: reset clearing pass, word walk and result hand-off.
module bre_seq #(
  parameter int NUM_WORDS = 64,
  parameter int AW        = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  bre_pkg::in_item_t           in_data,
  input  logic [bre_pkg::CFG_W-1:0]   bits_in_use,
  input  logic                        out_free,
  output logic                        push,
  output bre_pkg::out_item_t          push_item,
  output bre_pkg::seq_stat_t          stat,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [bre_pkg::DATA_W-1:0]  mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  output bre_pkg::wu_ctl_t            wu_ctl,
  input  bre_pkg::wu_res_t            wu_res
);
  import bre_pkg::*;

  localparam int CAP = NUM_WORDS * DATA_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

  seq_state_t state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [1:0]        op_r, op_nxt;
  logic              val_r, val_nxt;
  logic [WORD_W-1:0] fw_r, fw_nxt;
  logic [WORD_W-1:0] lw_r, lw_nxt;
  logic [BIT_W-1:0]  lo_r, lo_nxt;
  logic [BIT_W-1:0]  hi_r, hi_nxt;
  logic [WORD_W-1:0] wcur_r, wcur_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  out_item_t         res_r, res_nxt;

  logic [CFG_W-1:0]  n_size;
  logic [CFG_W-1:0]  nm1;
  logic              start_err;
  logic              range_err;
  logic              is_region;
  logic              zero_len;
  logic [CFG_W-1:0]  end1;
  logic [BIT_W-1:0]  p_off;
  logic [CNT_W-1:0]  cnt;
  logic [RUN_W-1:0]  run_sum;
  logic              work_done;
  out_item_t         work_item;

  // Size and range checks of the incoming command.
  always_comb begin
    n_size    = (int'(bits_in_use) < CAP) ? bits_in_use : CFG_W'(CAP);
    nm1       = n_size - CFG_W'(1);
    start_err = CFG_W'(in_data.start_req) >= n_size;
    is_region = (in_data.opcode == OP_WRITE) || (in_data.opcode == OP_TOGGLE);
    range_err = is_region &&
                ((14'(in_data.start_req) + 14'(in_data.length)) > 14'(n_size));
    zero_len  = in_data.length == '0;
    end1      = CFG_W'(in_data.start_req) + in_data.length - CFG_W'(1);
  end

  assign wu_ctl.opcode   = op_r;
  assign wu_ctl.value    = val_r;
  assign wu_ctl.first    = wcur_r == fw_r;
  assign wu_ctl.last_reg = wcur_r == lw_r;
  assign wu_ctl.lim_last = wcur_r == nm1[CFG_W-1:BIT_W];
  assign wu_ctl.lo       = lo_r;
  assign wu_ctl.hi       = hi_r;
  assign wu_ctl.lim_bit  = nm1[BIT_W-1:0];

  // Completion of the current word and the result it would give.
  always_comb begin
    p_off   = wu_ctl.first ? lo_r : '0;
    cnt     = wu_res.ones - CNT_W'(p_off);
    run_sum = run_r + RUN_W'(cnt);
    case (op_r)
      OP_WRITE, OP_TOGGLE: work_done = wu_ctl.last_reg;
      OP_COUNT:            work_done = !((wu_res.ones == FULL_WORD) && !wu_ctl.lim_last);
      default:             work_done = 1'b1;
    endcase
    work_item.bit_out   = (op_r == OP_READ) ? wu_res.bit_val : 1'b0;
    work_item.run_count = (op_r == OP_COUNT) ? run_sum : '0;
    work_item.status    = 1'b0;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (start_err || range_err || (is_region && zero_len)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_WORK;
          end
        end
      end
      ST_WORK: begin
        if (work_done) begin
          state_nxt = out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs and datapath register updates.
  always_comb begin
    push      = 1'b0;
    push_item = res_r;
    mem_we    = 1'b0;
    mem_waddr = AW'(wcur_r);
    mem_wdata = wu_res.new_word;
    mem_raddr = AW'(wcur_r + WORD_W'(1));
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    fw_nxt    = fw_r;
    lw_nxt    = lw_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    wcur_nxt  = wcur_r;
    run_nxt   = run_r;
    res_nxt   = res_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      ST_IDLE: begin
        mem_raddr = AW'(in_data.start_req[START_W-1:BIT_W]);
        if (in_valid) begin
          op_nxt   = in_data.opcode;
          val_nxt  = in_data.value;
          fw_nxt   = WORD_W'(in_data.start_req[START_W-1:BIT_W]);
          lw_nxt   = end1[CFG_W-1:BIT_W];
          lo_nxt   = in_data.start_req[BIT_W-1:0];
          hi_nxt   = end1[BIT_W-1:0];
          wcur_nxt = WORD_W'(in_data.start_req[START_W-1:BIT_W]);
          run_nxt  = '0;
          res_nxt.bit_out   = 1'b0;
          res_nxt.run_count = '0;
          res_nxt.status    = start_err || range_err;
        end
      end
      ST_WORK: begin
        mem_we = (op_r == OP_WRITE) || (op_r == OP_TOGGLE);
        if (!work_done) begin
          wcur_nxt = wcur_r + WORD_W'(1);
          run_nxt  = run_sum;
        end else if (out_free) begin
          push      = 1'b1;
          push_item = work_item;
        end else begin
          res_nxt = work_item;
        end
      end
      ST_DONE: begin
        push = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign stat.idle     = state_r == ST_IDLE;
  assign stat.clearing = state_r == ST_CLEAR;
  assign stat.mem_we   = mem_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    fw_r   <= fw_nxt;
    lw_r   <= lw_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    wcur_r <= wcur_nxt;
    run_r  <= run_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ----- hw/rtl/bitmap_region_engine.sv -----
// Bitmap region engine top level: configuration register, output register and core.
//
// A bitmap of NUM_WORDS 64-bit words is kept in an on-chip memory. Commands
// arrive on the in_ channel (valid/stall) and each one returns exactly one
// result transaction on the out_ channel: read a bit, fill or clear a range,
// toggle a range, or count a run of equal bits. cfg_wr_en with cfg_wr_data
// sets the number of bits in use; the user must write it only while no
// command is in flight, as the block itself does not enforce this.
// A command is accepted while the sequencer is idle, which also issues the
// first word read; then it does one read-modify-write step per memory word it
// touches, since the walk steps through the memory one word per cycle, and
// its result goes into the output register. Errors and zero-length regions
// need no memory access. The next command is taken in the cycle after the
// previous one completes, so no new command is taken before the previous
// result has been handed over.
// After reset the engine sweeps the memory to zero, one word per cycle, and
// stalls the input channel until the sweep is done.
// When the receiver stalls, the finished result waits in the output register
// and the engine can still accept and work on one more command; that command
// then holds its result until the output register frees up.
`include "bitmap_region_engine_assert.svh"

module bitmap_region_engine #(
  parameter int NUM_WORDS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bre_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bre_pkg::out_item_t          out_data,
  input  logic                        cfg_wr_en,
  input  logic [bre_pkg::CFG_W-1:0]   cfg_wr_data
);
  import bre_pkg::*;

  // Address width of the word memory; a single-word store still gets one bit.
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [CFG_W-1:0] bits_in_use_r, bits_in_use_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic              out_free;
  logic              push;
  out_item_t         push_item;
  seq_stat_t         seq_stat;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  wu_ctl_t           wu_ctl;
  wu_res_t           wu_res;

  // The output register is free when it is empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // Commands are taken only when the sequencer is idle; this also keeps the
  // next command's first read behind the previous command's last write, so
  // no forwarding path is needed.
  assign in_stall = !seq_stat.idle;

  bre_seq #(
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .bits_in_use (bits_in_use_r),
    .out_free    (out_free),
    .push        (push),
    .push_item   (push_item),
    .stat        (seq_stat),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .wu_ctl      (wu_ctl),
    .wu_res      (wu_res)
  );

  bre_store #(
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  bre_word_unit u_word_unit (
    .ctl     (wu_ctl),
    .rd_word (mem_rdata),
    .res     (wu_res)
  );

  always_comb begin
    bits_in_use_nxt = cfg_wr_en ? cfg_wr_data : bits_in_use_r;
    out_valid_nxt   = push || (out_valid_r && out_stall);
    out_data_nxt    = push ? push_item : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= BIU_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      bits_in_use_r <= bits_in_use_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result is handed over only when the output register can take it.
  `BRE_ASSERT_NOW(a_push_slot_free, clk, rst_n, push, !out_valid_r || !out_stall,
    "result pushed into a full output register")
  // One command at a time: an accepted command stalls the input next cycle.
  `BRE_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall,
    "second command accepted while one is in flight")
  // An error result carries no bit and no run length.
  `BRE_ASSERT_NOW(a_error_fields_zero, clk, rst_n, push && push_item.status,
    !push_item.bit_out && (push_item.run_count == '0),
    "error result with nonzero fields")
  // The memory is never written while the engine waits for a command.
  `BRE_ASSERT_NOW(a_no_idle_write, clk, rst_n, seq_stat.mem_we, !seq_stat.idle,
    "memory write while idle")
  // No command is taken while the clearing sweep is still running.
  `BRE_ASSERT_NOW(a_stall_while_clearing, clk, rst_n, seq_stat.clearing, in_stall,
    "input not stalled during the clearing sweep")

endmodule
